/* hw/rtl/sacp_pkg.sv */
// Shared types and constants of the set-associative cache tag policy unit.
package sacp_pkg;

	localparam int ADDR_W     = 32;
	localparam int TAG_W      = 32;
	localparam int RANK_W     = 3;
	localparam int OUT_WAY_W  = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;
	localparam int SHIFT_W    = 6;

	localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_STORE = 1'b1;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_FIFO   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK     = 3'd5;

	// reset values of the registers
	localparam logic [3:0] RST_INDEX_BITS     = 4'd0;
	localparam logic [3:0] RST_OFFSET_BITS    = 4'd4;
	localparam logic [3:0] RST_WAYS_USED      = 4'd1;
	localparam logic       RST_REPLACE_FIFO   = 1'b0;
	localparam logic       RST_WRITE_ALLOCATE = 1'b1;
	localparam logic       RST_WRITE_BACK     = 1'b1;

	// one way presented to the scan unit
	typedef struct packed {
		logic              first;
		logic              valid;
		logic [RANK_W-1:0] rank;
		logic [TAG_W-1:0]  tag;
	} scan_in_t;

endpackage

/* hw/rtl/sacp_ifs.sv */
// Request and response channel interfaces of the cache tag policy unit.
interface sacp_req_if import sacp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [ADDR_W-1:0] address;

	modport source(output valid, output mode, output address, input ready);
	modport sink(input valid, input mode, input address, output ready);
endinterface

interface sacp_rsp_if import sacp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic                 allocated;
	logic                 dirty_evicted;
	logic [OUT_WAY_W-1:0] way_used;

	modport source(output valid, output hit, output allocated, output dirty_evicted,
		output way_used, input ready);
	modport sink(input valid, input hit, input allocated, input dirty_evicted,
		input way_used, output ready);
endinterface

/* hw/rtl/set_assoc_cache_tag_policy_unit.sv */
// Set-associative cache tag store with LRU or FIFO replacement and write policies.
// Each request word carries a load or store and a 32-bit byte address. The low
// offset_bits bits are the byte offset, the next index_bits bits pick the set
// (capped at floor(log2(MAX_SETS))) and the bits above form the tag. The ways of the
// set are read from the tag memory one per cycle and run through a single
// compare unit, which also tracks the lowest empty way and the oldest way. On a
// miss the line goes to the lowest empty way, or else to the oldest way, whose
// dirty bit is reported as a dirty eviction. A store miss allocates only with
// write_allocate set; stores mark lines dirty only with write_back set. The scan
// stops at the hit way, or compares all active ways on a miss. The response word
// sits in an output register, so a stalled response holds only the following
// access, in its update step; no new request is taken until the current one has
// updated its set. The per-way tag scan through the one tag memory read port
// sets the access time. After reset the block clears the metadata memory, one
// set per cycle, and takes no request until that is done; configuration writes
// are taken at any time but are meant only while the block is idle.
module set_assoc_cache_tag_policy_unit import sacp_pkg::*; #(
	parameter int MAX_SETS  = 256,
	parameter int MAX_WAYS  = 8,
	parameter int ADDR_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sacp_req_if.sink              req,
	sacp_rsp_if.source            rsp
);

	localparam int MAX_IB  = $clog2(MAX_SETS + 1) - 1;
	localparam int SET_W   = (MAX_IB > 0) ? MAX_IB : 1;
	localparam int ROWS    = 1 << MAX_IB;
	localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int AW_W    = $clog2(MAX_WAYS + 1);
	localparam int LIMIT_W = RANK_W + 1;
	localparam logic [ADDR_W-1:0] AMASK = (ADDR_BITS >= ADDR_W) ? '1 :
		ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

	typedef struct packed {
		logic [MAX_WAYS-1:0]             valid;
		logic [MAX_WAYS-1:0]             dirty;
		logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
	} meta_row_t;

	localparam int ROW_W = $bits(meta_row_t);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	// configuration registers
	logic [3:0] index_bits_q;
	logic [3:0] offset_bits_q;
	logic [3:0] ways_used_q;
	logic       replace_fifo_q;
	logic       write_allocate_q;
	logic       write_back_q;

	// sequencer and response registers
	state_t               state_q;
	logic [SET_W-1:0]     clr_q;
	logic [WAY_W-1:0]     cmp_way_q;
	logic                 mode_q;
	logic [SET_W-1:0]     set_q;
	logic [TAG_W-1:0]     tag_q;
	logic                 rsp_valid_q;
	logic                 rsp_hit_q;
	logic                 rsp_alloc_q;
	logic                 rsp_dirty_q;
	logic [OUT_WAY_W-1:0] rsp_way_q;

	// address split
	logic [ADDR_W-1:0]  addr_m;
	logic [4:0]         ib_eff;
	logic [SHIFT_W-1:0] tag_shift;
	logic [ADDR_W-1:0]  addr_off;
	logic [SET_W-1:0]   set_in;
	logic [TAG_W-1:0]   tag_in;
	logic [4:0]         ways_wide;
	logic [AW_W-1:0]    ways_act;

	// memories
	logic [ROW_W-1:0] meta_rd_row;
	meta_row_t        meta_cur;
	meta_row_t        row_n;
	logic             meta_wr_en;
	logic [SET_W-1:0] meta_wr_set;
	logic [ROW_W-1:0] meta_wr_row;
	logic             tag_rd_en;
	logic [SET_W+WAY_W-1:0] tag_rd_addr;
	logic [TAG_W-1:0] tag_rd_data;

	// scan unit
	scan_in_t         probe;
	logic             sc_hit_now;
	logic             sc_hit;
	logic [WAY_W-1:0] sc_hit_way;
	logic             sc_empty_found;
	logic [WAY_W-1:0] sc_empty_way;
	logic [WAY_W-1:0] sc_best_way;
	logic             last_way;

	// update
	logic               accept;
	logic               commit;
	logic               is_store;
	logic               mark_dirty;
	logic [WAY_W-1:0]   tgt_way;
	logic [LIMIT_W-1:0] age_limit;
	logic               age_en;
	logic               fill;
	logic               devict;

	// ---------------------------------------------------------------
	// Configuration
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q     <= RST_INDEX_BITS;
			offset_bits_q    <= RST_OFFSET_BITS;
			ways_used_q      <= RST_WAYS_USED;
			replace_fifo_q   <= RST_REPLACE_FIFO;
			write_allocate_q <= RST_WRITE_ALLOCATE;
			write_back_q     <= RST_WRITE_BACK;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_INDEX_BITS:     index_bits_q     <= cfg_data;
				CFG_OFFSET_BITS:    offset_bits_q    <= cfg_data;
				CFG_WAYS_USED:      ways_used_q      <= cfg_data;
				CFG_REPLACE_FIFO:   replace_fifo_q   <= cfg_data[0];
				CFG_WRITE_ALLOCATE: write_allocate_q <= cfg_data[0];
				CFG_WRITE_BACK:     write_back_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp the set count to what the memory holds and the way count to 1..MAX_WAYS.
	assign ib_eff = ({1'b0, index_bits_q} > 5'(MAX_IB)) ? 5'(MAX_IB) : {1'b0, index_bits_q};
	assign ways_wide = (ways_used_q == 4'd0) ? 5'd1 :
		(({1'b0, ways_used_q} > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : {1'b0, ways_used_q});
	assign ways_act = AW_W'(ways_wide);

	// ---------------------------------------------------------------
	// Address split
	// ---------------------------------------------------------------
	assign addr_m    = req.address & AMASK;
	assign addr_off  = addr_m >> offset_bits_q;
	assign set_in    = SET_W'(addr_off) & ~({SET_W{1'b1}} << ib_eff);
	assign tag_shift = SHIFT_W'(offset_bits_q) + SHIFT_W'(ib_eff);
	assign tag_in    = TAG_W'(addr_m >> tag_shift);

	assign accept    = (state_q == ST_IDLE) && req.valid;
	assign req.ready = (state_q == ST_IDLE);

	// ---------------------------------------------------------------
	// Memories
	// ---------------------------------------------------------------
	assign meta_cur  = meta_rd_row;
	assign tag_rd_en = accept || (state_q == ST_SCAN);
	// Prefetch the next way's tag while the current one is compared.
	assign tag_rd_addr = (state_q == ST_IDLE) ? {set_in, WAY_W'(0)} :
		{set_q, cmp_way_q + WAY_W'(1)};

	assign meta_wr_en  = (state_q == ST_CLEAR) || commit;
	assign meta_wr_set = (state_q == ST_CLEAR) ? clr_q : set_q;
	assign meta_wr_row = (state_q == ST_CLEAR) ? '0 : row_n;

	sacp_line_store #(
		.SET_W(SET_W),
		.ROWS (ROWS),
		.WAY_W(WAY_W),
		.ROW_W(ROW_W)
	) u_store (
		.clk        (clk),
		.meta_rd_en (accept),
		.meta_rd_set(set_in),
		.meta_rd_row(meta_rd_row),
		.meta_wr_en (meta_wr_en),
		.meta_wr_set(meta_wr_set),
		.meta_wr_row(meta_wr_row),
		.tag_rd_en  (tag_rd_en),
		.tag_rd_addr(tag_rd_addr),
		.tag_rd_data(tag_rd_data),
		.tag_wr_en  (commit && fill),
		.tag_wr_addr({set_q, tgt_way}),
		.tag_wr_data(tag_q)
	);

	// ---------------------------------------------------------------
	// Way scan
	// ---------------------------------------------------------------
	assign probe.first = (cmp_way_q == '0);
	assign probe.valid = meta_cur.valid[cmp_way_q];
	assign probe.rank  = meta_cur.rank[cmp_way_q];
	assign probe.tag   = tag_rd_data;

	sacp_way_scan #(
		.WAY_W(WAY_W)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (state_q == ST_SCAN),
		.way        (cmp_way_q),
		.probe      (probe),
		.key        (tag_q),
		.hit_now    (sc_hit_now),
		.hit_found  (sc_hit),
		.hit_way    (sc_hit_way),
		.empty_found(sc_empty_found),
		.empty_way  (sc_empty_way),
		.best_way   (sc_best_way)
	);

	assign last_way = (AW_W'(cmp_way_q) == ways_act - AW_W'(1));

	// ---------------------------------------------------------------
	// Line update: pick the target way, age the set, fill or mark
	// ---------------------------------------------------------------
	assign is_store   = (mode_q == MODE_STORE);
	assign mark_dirty = is_store && write_back_q;
	assign commit     = (state_q == ST_UPDATE) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		row_n     = meta_cur;
		tgt_way   = '0;
		age_limit = '0;
		age_en    = 1'b0;
		fill      = 1'b0;
		devict    = 1'b0;
		if (sc_hit) begin
			tgt_way = sc_hit_way;
			if (!replace_fifo_q) begin
				// LRU hit: age only the ways younger than the hit way
				age_en    = 1'b1;
				age_limit = {1'b0, meta_cur.rank[sc_hit_way]};
			end
		end else if (!is_store || write_allocate_q) begin
			fill   = 1'b1;
			age_en = 1'b1;
			if (sc_empty_found) begin
				tgt_way   = sc_empty_way;
				age_limit = LIMIT_W'(RANK_MAX) + LIMIT_W'(1);
			end else begin
				tgt_way   = sc_best_way;
				age_limit = {1'b0, meta_cur.rank[sc_best_way]};
				devict    = meta_cur.dirty[sc_best_way];
			end
		end
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (age_en && (WAY_W'(w) != tgt_way) && (AW_W'(w) < ways_act) &&
				meta_cur.valid[w] && ({1'b0, meta_cur.rank[w]} < age_limit) &&
				(meta_cur.rank[w] != RANK_MAX)) begin
				row_n.rank[w] = meta_cur.rank[w] + RANK_W'(1);
			end
		end
		if (sc_hit) begin
			if (!replace_fifo_q) begin
				row_n.rank[tgt_way] = '0;
			end
			if (mark_dirty) begin
				row_n.dirty[tgt_way] = 1'b1;
			end
		end
		if (fill) begin
			row_n.valid[tgt_way] = 1'b1;
			row_n.dirty[tgt_way] = mark_dirty;
			row_n.rank[tgt_way]  = '0;
		end
	end

	// ---------------------------------------------------------------
	// Sequencer and response register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cmp_way_q   <= '0;
			mode_q      <= MODE_LOAD;
			set_q       <= '0;
			tag_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_hit_q   <= 1'b0;
			rsp_alloc_q <= 1'b0;
			rsp_dirty_q <= 1'b0;
			rsp_way_q   <= '0;
		end else begin
			// load the response word on a commit, drop it once taken
			if (commit) begin
				rsp_valid_q <= 1'b1;
				rsp_hit_q   <= sc_hit;
				rsp_alloc_q <= fill;
				rsp_dirty_q <= devict;
				rsp_way_q   <= OUT_WAY_W'(tgt_way);
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SET_W'(1);
					if (clr_q == SET_W'(ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						mode_q    <= req.mode;
						set_q     <= set_in;
						tag_q     <= tag_in;
						cmp_way_q <= '0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// stop at the first hit or after the last active way
					if (sc_hit_now || last_way) begin
						state_q <= ST_UPDATE;
					end else begin
						cmp_way_q <= cmp_way_q + WAY_W'(1);
					end
				end
				ST_UPDATE: begin
					// hold until the response register is free
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.hit           = rsp_hit_q;
	assign rsp.allocated     = rsp_alloc_q;
	assign rsp.dirty_evicted = rsp_dirty_q;
	assign rsp.way_used      = rsp_way_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_rsp_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_UPDATE))
		else $error("response word raised outside the update step");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (AW_W'(cmp_way_q) < ways_act))
		else $error("way scan ran past the active ways");

	a_evict_only_on_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_dirty_q) |-> (rsp_alloc_q && !rsp_hit_q))
		else $error("dirty eviction reported without a fill on a miss");

	a_hit_no_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_hit_q && rsp_alloc_q))
		else $error("hit and allocation reported together");

endmodule

/* hw/rtl/sacp_way_scan.sv */
// Shared way scan unit: tag compare, first empty way and oldest way, one way per step.
module sacp_way_scan import sacp_pkg::*; #(
	parameter int WAY_W = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [WAY_W-1:0] way,
	input  scan_in_t         probe,
	input  logic [TAG_W-1:0] key,
	output logic             hit_now,
	output logic             hit_found,
	output logic [WAY_W-1:0] hit_way,
	output logic             empty_found,
	output logic [WAY_W-1:0] empty_way,
	output logic [WAY_W-1:0] best_way
);

	logic [RANK_W-1:0] best_rank_q;

	assign hit_now = probe.valid && (probe.tag == key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found   <= 1'b0;
			hit_way     <= '0;
			empty_found <= 1'b0;
			empty_way   <= '0;
			best_way    <= '0;
			best_rank_q <= '0;
		end else if (step) begin
			if (probe.first) begin
				hit_found   <= hit_now;
				hit_way     <= way;
				empty_found <= !probe.valid;
				empty_way   <= way;
				best_way    <= way;
				best_rank_q <= probe.rank;
			end else begin
				if (!hit_found && hit_now) begin
					hit_found <= 1'b1;
					hit_way   <= way;
				end
				if (!empty_found && !probe.valid) begin
					empty_found <= 1'b1;
					empty_way   <= way;
				end
				// strict compare: ties keep the lower way
				if (probe.rank > best_rank_q) begin
					best_way    <= way;
					best_rank_q <= probe.rank;
				end
			end
		end
	end

endmodule

/* hw/rtl/sacp_line_store.sv */
// Line state memories: one metadata row per set and one tag word per line.
module sacp_line_store import sacp_pkg::*; #(
	parameter int SET_W = 8,
	parameter int ROWS  = 256,
	parameter int WAY_W = 3,
	parameter int ROW_W = 40
) (
	input  logic                   clk,
	input  logic                   meta_rd_en,
	input  logic [SET_W-1:0]       meta_rd_set,
	output logic [ROW_W-1:0]       meta_rd_row,
	input  logic                   meta_wr_en,
	input  logic [SET_W-1:0]       meta_wr_set,
	input  logic [ROW_W-1:0]       meta_wr_row,
	input  logic                   tag_rd_en,
	input  logic [SET_W+WAY_W-1:0] tag_rd_addr,
	output logic [TAG_W-1:0]       tag_rd_data,
	input  logic                   tag_wr_en,
	input  logic [SET_W+WAY_W-1:0] tag_wr_addr,
	input  logic [TAG_W-1:0]       tag_wr_data
);

	localparam int TAG_ROWS = ROWS << WAY_W;

	logic [ROW_W-1:0] meta_mem [ROWS];
	logic [TAG_W-1:0] tag_mem  [TAG_ROWS];

	always_ff @(posedge clk) begin
		if (meta_wr_en) begin
			meta_mem[meta_wr_set] <= meta_wr_row;
		end
		if (meta_rd_en) begin
			meta_rd_row <= meta_mem[meta_rd_set];
		end
	end

	always_ff @(posedge clk) begin
		if (tag_wr_en) begin
			tag_mem[tag_wr_addr] <= tag_wr_data;
		end
		if (tag_rd_en) begin
			tag_rd_data <= tag_mem[tag_rd_addr];
		end
	end

endmodule
